// ----- sv/msad_pkg.sv -----
// Shared types, constants and tables for the stereo MS ADPCM decoder.
// No dependencies; used by every other file of the block.
`default_nettype none

package msad_pkg;

	// Field widths
	localparam int SPB_W    = 14;
	localparam int BYTE_W   = 8;
	localparam int SAMPLE_W = 16;
	localparam int POS_W    = 4;
	localparam int PIDX_W   = 3;

	// Defaults
	localparam int DEF_MAX_BLOCK_PAIRS = 8192;
	localparam logic [SPB_W-1:0] SPB_RESET = 14'd1012;

	// Byte positions in a block
	localparam logic [POS_W-1:0] POS_PIDX_L   = 4'd0;
	localparam logic [POS_W-1:0] POS_PIDX_R   = 4'd1;
	localparam logic [POS_W-1:0] POS_STEP_L   = 4'd3;
	localparam logic [POS_W-1:0] POS_STEP_R   = 4'd5;
	localparam logic [POS_W-1:0] POS_NEW_L    = 4'd7;
	localparam logic [POS_W-1:0] POS_NEW_R    = 4'd9;
	localparam logic [POS_W-1:0] POS_OLD_L    = 4'd11;
	localparam logic [POS_W-1:0] POS_HDR_LAST = 4'd13;
	localparam logic [POS_W-1:0] POS_DATA     = 4'd14;

	localparam logic [PIDX_W-1:0] PIDX_MAX = 3'd6;
	localparam logic signed [SAMPLE_W-1:0] STEP_FLOOR = 16'sd16;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	// Output queue depth
	localparam int OQ_DEPTH = 4;

	// One result beat
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_sample;
		logic signed [SAMPLE_W-1:0] right_sample;
		logic                       last_of_block;
		logic                       bad_predictor;
	} pair_t;

	// Up to two beats pushed in one cycle
	typedef struct packed {
		logic [1:0] num;
		pair_t      d0;
		pair_t      d1;
	} push_t;

	// Per-channel decoder state
	typedef struct packed {
		logic [PIDX_W-1:0]          pidx;
		logic signed [SAMPLE_W-1:0] step;
		logic signed [SAMPLE_W-1:0] newest;
		logic signed [SAMPLE_W-1:0] older;
	} chan_t;

	// Step adaptation factors (x/256)
	function automatic logic [9:0] adapt_f(input logic [3:0] nib);
		logic [9:0] r;
		case (nib)
			4'd4, 4'd12: r = 10'd307;
			4'd5, 4'd11: r = 10'd409;
			4'd6, 4'd10: r = 10'd512;
			4'd7, 4'd9:  r = 10'd614;
			4'd8:        r = 10'd768;
			default:     r = 10'd230;
		endcase
		return r;
	endfunction

	// Predictor coefficient for the newest sample
	function automatic logic signed [10:0] coef_a_f(input logic [PIDX_W-1:0] p);
		logic signed [10:0] r;
		case (p)
			3'd0:    r = 11'sd256;
			3'd1:    r = 11'sd512;
			3'd2:    r = 11'sd0;
			3'd3:    r = 11'sd192;
			3'd4:    r = 11'sd240;
			3'd5:    r = 11'sd460;
			default: r = 11'sd392;
		endcase
		return r;
	endfunction

	// Predictor coefficient for the older sample
	function automatic logic signed [9:0] coef_b_f(input logic [PIDX_W-1:0] p);
		logic signed [9:0] r;
		case (p)
			3'd0:    r = 10'sd0;
			3'd1:    r = -10'sd256;
			3'd2:    r = 10'sd0;
			3'd3:    r = 10'sd64;
			3'd4:    r = 10'sd0;
			3'd5:    r = -10'sd208;
			default: r = -10'sd232;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/msad_if.sv -----
// Valid/ready channel interfaces: byte input and stereo pair output.
// Depends on msad_pkg for field widths.
`default_nettype none

interface msad_byte_if;
	logic                          valid;
	logic                          ready;
	logic [msad_pkg::BYTE_W-1:0]   data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface msad_pair_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [msad_pkg::SAMPLE_W-1:0] left_sample;
	logic signed [msad_pkg::SAMPLE_W-1:0] right_sample;
	logic                                 last_of_block;
	logic                                 bad_predictor;

	modport source (output valid, output left_sample, output right_sample,
		output last_of_block, output bad_predictor, input ready);
	modport sink   (input valid, input left_sample, input right_sample,
		input last_of_block, input bad_predictor, output ready);
endinterface

`default_nettype wire

// ----- sv/msad_chan.sv -----
// One channel's nibble update: prediction, clamp and step adaptation.
// Pure combinational; depends on msad_pkg.
`default_nettype none

module msad_chan (
	input  wire msad_pkg::chan_t   cur,
	input  wire logic [3:0]        nib,
	output msad_pkg::chan_t        nxt
);

	logic [msad_pkg::PIDX_W-1:0] p;
	logic signed [26:0] pa;
	logic signed [26:0] pb;
	logic signed [27:0] acc;
	logic signed [27:0] acc_adj;
	logic signed [19:0] pred;
	logic signed [3:0]  sn;
	logic signed [19:0] dq;
	logic signed [20:0] s;
	logic signed [15:0] s_clamp;
	logic signed [10:0] ad_s;
	logic signed [26:0] sp;
	logic signed [26:0] sp_adj;
	logic signed [15:0] st16;

	// prediction, truncated toward zero
	assign p       = (cur.pidx > msad_pkg::PIDX_MAX) ? msad_pkg::PIDX_MAX : cur.pidx;
	assign pa      = 27'(cur.newest) * 27'(msad_pkg::coef_a_f(p));
	assign pb      = 27'(cur.older) * 27'(msad_pkg::coef_b_f(p));
	assign acc     = 28'(pa) + 28'(pb);
	assign acc_adj = acc + (acc[27] ? 28'sd255 : 28'sd0);
	assign pred    = acc_adj[27:8];

	// add scaled nibble and clamp to 16 bits
	assign sn = $signed(nib);
	assign dq = 20'(cur.step) * 20'(sn);
	assign s  = 21'(pred) + 21'(dq);

	always_comb begin
		if (s > 21'(msad_pkg::SAMPLE_MAX)) begin
			s_clamp = msad_pkg::SAMPLE_MAX;
		end else if (s < 21'(msad_pkg::SAMPLE_MIN)) begin
			s_clamp = msad_pkg::SAMPLE_MIN;
		end else begin
			s_clamp = s[15:0];
		end
	end

	// step adaptation: scale, truncate, wrap to 16 bits, floor
	assign ad_s   = $signed({1'b0, msad_pkg::adapt_f(nib)});
	assign sp     = 27'(cur.step) * 27'(ad_s);
	assign sp_adj = sp + (sp[26] ? 27'sd255 : 27'sd0);
	assign st16   = sp_adj[23:8];

	always_comb begin
		nxt.pidx   = cur.pidx;
		nxt.step   = (st16 < msad_pkg::STEP_FLOOR) ? msad_pkg::STEP_FLOOR : st16;
		nxt.newest = s_clamp;
		nxt.older  = cur.newest;
	end

endmodule

`default_nettype wire

// ----- sv/msad_oq.sv -----
// Small output queue: takes up to two result beats a cycle, sends one when the sink is ready.
// Depends on msad_pkg and msad_if.
`default_nettype none

module msad_oq (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire msad_pkg::push_t push,
	output logic                 room,
	msad_pair_if.source          pair_out
);

	localparam int IDX_W = $clog2(msad_pkg::OQ_DEPTH);
	localparam int CNT_W = $clog2(msad_pkg::OQ_DEPTH + 1);

	msad_pkg::pair_t  mem_q [msad_pkg::OQ_DEPTH];
	logic [IDX_W-1:0] wr_q;
	logic [IDX_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;
	logic [IDX_W-1:0] wr_p1;
	msad_pkg::pair_t  head;

	assign pop   = pair_out.valid && pair_out.ready;
	assign wr_p1 = wr_q + IDX_W'(1);
	// space for a two-beat push regardless of the sink
	assign room  = cnt_q <= CNT_W'(msad_pkg::OQ_DEPTH - 2);

	// storage
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_q] <= push.d0;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_p1] <= push.d1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + IDX_W'(push.num);
			if (pop) begin
				rd_q <= rd_q + IDX_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push.num) - CNT_W'(pop);
		end
	end

	// head beat
	assign head                   = mem_q[rd_q];
	assign pair_out.valid         = cnt_q != '0;
	assign pair_out.left_sample   = head.left_sample;
	assign pair_out.right_sample  = head.right_sample;
	assign pair_out.last_of_block = head.last_of_block;
	assign pair_out.bad_predictor = head.bad_predictor;

endmodule

`default_nettype wire

// ----- sv/msad_dec.sv -----
// Input register, block header parser and per-byte stereo decode.
// Depends on msad_pkg, msad_if and msad_chan.
`default_nettype none

module msad_dec #(
	parameter int MAX_BLOCK_PAIRS = msad_pkg::DEF_MAX_BLOCK_PAIRS
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire [msad_pkg::SPB_W-1:0]      samples_per_block,
	input  wire                            room,
	output msad_pkg::push_t                push,
	msad_byte_if.sink                      byte_in
);

	localparam int PAIR_W = $clog2(MAX_BLOCK_PAIRS + 1);
	localparam int CMP_W  = (PAIR_W > msad_pkg::SPB_W) ? PAIR_W : msad_pkg::SPB_W;

	// input stage
	logic                        valid_s1;
	logic [msad_pkg::BYTE_W-1:0] byte_s1;
	logic                        go;

	// block state
	logic [msad_pkg::POS_W-1:0]  pos_q;
	logic [PAIR_W-1:0]           pairs_q;
	logic [msad_pkg::BYTE_W-1:0] latch_q;
	logic                        perr_q;
	msad_pkg::chan_t             ch_q [2];

	// next-state
	logic [msad_pkg::POS_W-1:0]  pos_d;
	logic [PAIR_W-1:0]           pairs_d;
	logic [msad_pkg::BYTE_W-1:0] latch_d;
	logic                        perr_d;
	msad_pkg::chan_t             ch_d [2];
	msad_pkg::chan_t             dec_l;
	msad_pkg::chan_t             dec_r;

	logic [CMP_W-1:0]            spb_c;
	logic [CMP_W-1:0]            blk_len;
	logic [PAIR_W-1:0]           pairs_inc;
	logic                        bad_idx;
	logic [msad_pkg::PIDX_W-1:0] idx_clamped;
	logic signed [15:0]          word;

	assign go            = valid_s1 && room;
	assign byte_in.ready = !valid_s1 || go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.valid && byte_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.data_byte;
		end
	end

	// effective block length
	assign spb_c = CMP_W'(samples_per_block);
	always_comb begin
		if (spb_c < CMP_W'(2)) begin
			blk_len = CMP_W'(2);
		end else if (spb_c > CMP_W'(MAX_BLOCK_PAIRS)) begin
			blk_len = CMP_W'(MAX_BLOCK_PAIRS);
		end else begin
			blk_len = spb_c;
		end
	end

	// data byte: high nibble left, low nibble right
	msad_chan u_chan_l (.cur(ch_q[0]), .nib(byte_s1[7:4]), .nxt(dec_l));
	msad_chan u_chan_r (.cur(ch_q[1]), .nib(byte_s1[3:0]), .nxt(dec_r));

	assign pairs_inc   = pairs_q + PAIR_W'(1);
	assign bad_idx     = byte_s1 > 8'(msad_pkg::PIDX_MAX);
	assign idx_clamped = bad_idx ? msad_pkg::PIDX_MAX : byte_s1[msad_pkg::PIDX_W-1:0];
	assign word        = $signed({byte_s1, latch_q});

	// header parse and decode
	always_comb begin
		pos_d    = pos_q;
		pairs_d  = pairs_q;
		latch_d  = latch_q;
		perr_d   = perr_q;
		ch_d[0]  = ch_q[0];
		ch_d[1]  = ch_q[1];
		push.num = 2'd0;
		push.d0  = '0;
		push.d1  = '0;

		case (pos_q)
			msad_pkg::POS_PIDX_L: begin
				ch_d[0].pidx = idx_clamped;
				perr_d       = bad_idx;
				pos_d        = pos_q + 4'd1;
			end
			msad_pkg::POS_PIDX_R: begin
				ch_d[1].pidx = idx_clamped;
				perr_d       = perr_q | bad_idx;
				pos_d        = pos_q + 4'd1;
			end
			msad_pkg::POS_STEP_L: begin
				ch_d[0].step = word;
				pos_d        = pos_q + 4'd1;
			end
			msad_pkg::POS_STEP_R: begin
				ch_d[1].step = word;
				pos_d        = pos_q + 4'd1;
			end
			msad_pkg::POS_NEW_L: begin
				ch_d[0].newest = word;
				pos_d          = pos_q + 4'd1;
			end
			msad_pkg::POS_NEW_R: begin
				ch_d[1].newest = word;
				pos_d          = pos_q + 4'd1;
			end
			msad_pkg::POS_OLD_L: begin
				ch_d[0].older = word;
				pos_d         = pos_q + 4'd1;
			end
			msad_pkg::POS_HDR_LAST: begin
				// older pair, then newest pair
				ch_d[1].older = word;
				push.num = 2'd2;
				push.d0.left_sample   = ch_q[0].older;
				push.d0.right_sample  = word;
				push.d0.last_of_block = 1'b0;
				push.d0.bad_predictor = perr_q;
				push.d1.left_sample   = ch_q[0].newest;
				push.d1.right_sample  = ch_q[1].newest;
				push.d1.last_of_block = blk_len == CMP_W'(2);
				push.d1.bad_predictor = perr_q;
				if (blk_len == CMP_W'(2)) begin
					pos_d   = msad_pkg::POS_PIDX_L;
					pairs_d = '0;
				end else begin
					pos_d   = msad_pkg::POS_DATA;
					pairs_d = PAIR_W'(2);
				end
			end
			msad_pkg::POS_DATA: begin
				ch_d[0]  = dec_l;
				ch_d[1]  = dec_r;
				push.num = 2'd1;
				push.d0.left_sample   = dec_l.newest;
				push.d0.right_sample  = dec_r.newest;
				push.d0.last_of_block = CMP_W'(pairs_inc) >= blk_len;
				push.d0.bad_predictor = perr_q;
				if (CMP_W'(pairs_inc) >= blk_len) begin
					pos_d   = msad_pkg::POS_PIDX_L;
					pairs_d = '0;
				end else begin
					pairs_d = pairs_inc;
				end
			end
			default: begin
				// low byte of a header word
				latch_d = byte_s1;
				pos_d   = pos_q + 4'd1;
			end
		endcase

		if (!go) begin
			push.num = 2'd0;
		end
	end

	// block state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= msad_pkg::POS_PIDX_L;
			pairs_q <= '0;
			latch_q <= '0;
			perr_q  <= 1'b0;
			ch_q[0] <= '0;
			ch_q[1] <= '0;
		end else if (go) begin
			pos_q   <= pos_d;
			pairs_q <= pairs_d;
			latch_q <= latch_d;
			perr_q  <= perr_d;
			ch_q[0] <= ch_d[0];
			ch_q[1] <= ch_d[1];
		end
	end

endmodule

`default_nettype wire

// ----- sv/ms_adpcm_stereo_decoder.sv -----
// Top level of the stereo MS ADPCM block decoder.
// Depends on msad_pkg, msad_if, msad_dec and msad_oq.
//
//   channel     dir  beat contents
//   byte_in     in   data_byte (one stream byte)
//   pair_out    out  left_sample, right_sample, last_of_block, bad_predictor
//   cfg_we/data in   samples_per_block write
//
// One byte is taken per cycle while the output queue has room; a byte is held in
// the input register and its result beats are written into a four-entry output queue.
// The last header byte pushes two beats; other header bytes push none.
// Bytes stall only when the output queue holds more than two beats.
// Reset clears the block state to the start of a header; samples_per_block
// resets to 1012.
`default_nettype none

module ms_adpcm_stereo_decoder #(
	parameter int MAX_BLOCK_PAIRS = msad_pkg::DEF_MAX_BLOCK_PAIRS
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire [msad_pkg::SPB_W-1:0]  cfg_data,
	msad_byte_if.sink                  byte_in,
	msad_pair_if.source                pair_out
);

	logic [msad_pkg::SPB_W-1:0] spb_q;
	msad_pkg::push_t            push;
	logic                       room;

	// samples_per_block register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q <= msad_pkg::SPB_RESET;
		end else if (cfg_we) begin
			spb_q <= cfg_data;
		end
	end

	msad_dec #(
		.MAX_BLOCK_PAIRS(MAX_BLOCK_PAIRS)
	) u_dec (
		.clk              (clk),
		.arst_n           (arst_n),
		.samples_per_block(spb_q),
		.room             (room),
		.push             (push),
		.byte_in          (byte_in)
	);

	msad_oq u_oq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.pair_out(pair_out)
	);

endmodule

`default_nettype wire

// ----- test/ms_adpcm_stereo_decoder_test.sv -----
// Self-checking testbench for the stereo MS ADPCM block decoder.
// Needs msad_pkg, msad_if and ms_adpcm_stereo_decoder; a built-in decoder predicts every pair.
`timescale 1ns / 1ps

module ms_adpcm_stereo_decoder_test;

	localparam int MAX_PAIRS     = msad_pkg::DEF_MAX_BLOCK_PAIRS;
	localparam int SETTLE_CYCLES = 6;
	localparam int TAIL_CYCLES   = 20;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_ITEMS  = 630;
	localparam int LONG_DATA     = 120;
	localparam int SHOW_LIMIT    = 10;

	// Receiver stall styles
	typedef enum logic [1:0] {RX_OPEN, RX_PLAIN, RX_DENSE, RX_SPARSE} rx_mode_e;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [msad_pkg::SPB_W-1:0] cfg_data;

	msad_byte_if byte_in ();
	msad_pair_if pair_out ();

	ms_adpcm_stereo_decoder #(.MAX_BLOCK_PAIRS(MAX_PAIRS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.byte_in(byte_in),
		.pair_out(pair_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder state as the checker sees it
	logic [msad_pkg::SPB_W-1:0]  model_block_len;
	logic [msad_pkg::POS_W-1:0]  hdr_pos;
	int                          pairs_in_block;
	logic [7:0]                  low_latch;
	logic [msad_pkg::PIDX_W-1:0] ch_pidx [2];
	logic signed [15:0]          ch_step [2];
	logic signed [15:0]          ch_newest [2];
	logic signed [15:0]          ch_older [2];
	logic                        bad_pidx;
	msad_pkg::pair_t             pending_pairs [$];
	int                          mismatch_count = 0;
	int                          cycle_count = 0;

	// Stimulus side bookkeeping
	logic [msad_pkg::SPB_W-1:0] len_setting = msad_pkg::SPB_RESET;
	int                         open_pairs = 0;
	int                         burst_left = 0;
	int                         bytes_sent = 0;

	// Receiver pattern state
	rx_mode_e    rx_mode;
	logic [15:0] rx_pattern = 16'hFFFF;
	int          rx_run = 0;

	function automatic int pairs_per_block(input logic [msad_pkg::SPB_W-1:0] v);
		if (v < 2) return 2;
		if (v > MAX_PAIRS) return MAX_PAIRS;
		return int'(v);
	endfunction

	function automatic int coef_newest(input logic [msad_pkg::PIDX_W-1:0] p);
		case (p)
			3'd0: return 256;
			3'd1: return 512;
			3'd2: return 0;
			3'd3: return 192;
			3'd4: return 240;
			3'd5: return 460;
			default: return 392;
		endcase
	endfunction

	function automatic int coef_older(input logic [msad_pkg::PIDX_W-1:0] p);
		case (p)
			3'd1: return -256;
			3'd3: return 64;
			3'd5: return -208;
			3'd6: return -232;
			default: return 0;
		endcase
	endfunction

	function automatic int adapt_factor(input logic [3:0] nib);
		case (nib)
			4'd4, 4'd12: return 307;
			4'd5, 4'd11: return 409;
			4'd6, 4'd10: return 512;
			4'd7, 4'd9: return 614;
			4'd8: return 768;
			default: return 230;
		endcase
	endfunction

	// One channel update from a 4-bit code
	function automatic void decode_nibble(input int c, input logic [3:0] nib);
		int nw, od, pred, sn, s, st;
		logic signed [15:0] st16;
		nw = ch_newest[c];
		od = ch_older[c];
		pred = (nw * coef_newest(ch_pidx[c]) + od * coef_older(ch_pidx[c])) / 256;
		sn = nib[3] ? int'(nib) - 16 : int'(nib);
		s = pred + ch_step[c] * sn;
		if (s > 32767) s = 32767;
		if (s < -32768) s = -32768;
		st = ch_step[c] * adapt_factor(nib) / 256;
		st16 = st[15:0];
		st = st16;
		if (st < 16) st = 16;
		ch_step[c] = st[15:0];
		ch_older[c] = ch_newest[c];
		ch_newest[c] = s[15:0];
	endfunction

	function automatic void push_pair(input logic signed [15:0] l, input logic signed [15:0] r,
			input logic last);
		msad_pkg::pair_t p;
		p.left_sample = l;
		p.right_sample = r;
		p.last_of_block = last;
		p.bad_predictor = bad_pidx;
		pending_pairs.push_back(p);
	endfunction

	// Advance the model by one stream byte, queueing the pairs it yields
	function automatic void decode_byte(input logic [7:0] b);
		logic signed [15:0] word;
		logic last;
		if (hdr_pos == msad_pkg::POS_PIDX_L || hdr_pos == msad_pkg::POS_PIDX_R) begin
			if (hdr_pos == msad_pkg::POS_PIDX_L) bad_pidx = 1'b0;
			if (b > msad_pkg::PIDX_MAX) begin
				ch_pidx[hdr_pos[0]] = msad_pkg::PIDX_MAX;
				bad_pidx = 1'b1;
			end else begin
				ch_pidx[hdr_pos[0]] = b[msad_pkg::PIDX_W-1:0];
			end
			hdr_pos = hdr_pos + 4'd1;
		end else if (hdr_pos < msad_pkg::POS_DATA) begin
			if (!hdr_pos[0]) begin
				low_latch = b;
				hdr_pos = hdr_pos + 4'd1;
			end else begin
				word = {b, low_latch};
				case (hdr_pos)
					msad_pkg::POS_STEP_L: ch_step[0] = word;
					msad_pkg::POS_STEP_R: ch_step[1] = word;
					msad_pkg::POS_NEW_L: ch_newest[0] = word;
					msad_pkg::POS_NEW_R: ch_newest[1] = word;
					msad_pkg::POS_OLD_L: ch_older[0] = word;
					msad_pkg::POS_HDR_LAST: ch_older[1] = word;
					default: ;
				endcase
				if (hdr_pos != msad_pkg::POS_HDR_LAST) begin
					hdr_pos = hdr_pos + 4'd1;
				end else begin
					// header closes: older pair, then newest pair
					pairs_in_block = 2;
					last = pairs_in_block >= pairs_per_block(model_block_len);
					push_pair(ch_older[0], ch_older[1], 1'b0);
					push_pair(ch_newest[0], ch_newest[1], last);
					hdr_pos = last ? msad_pkg::POS_PIDX_L : msad_pkg::POS_DATA;
					if (last) pairs_in_block = 0;
				end
			end
		end else begin
			decode_nibble(0, b[7:4]);
			decode_nibble(1, b[3:0]);
			pairs_in_block++;
			last = pairs_in_block >= pairs_per_block(model_block_len);
			push_pair(ch_newest[0], ch_newest[1], last);
			if (last) begin
				hdr_pos = msad_pkg::POS_PIDX_L;
				pairs_in_block = 0;
			end
		end
	endfunction

	// Scoreboard: check output beats, then track config writes and input beats
	always @(posedge clk) begin : scoreboard
		msad_pkg::pair_t seen, want;
		if (!arst_n) begin
			model_block_len = msad_pkg::SPB_RESET;
			hdr_pos = msad_pkg::POS_PIDX_L;
			pairs_in_block = 0;
			low_latch = '0;
			bad_pidx = 1'b0;
			for (int c = 0; c < 2; c++) begin
				ch_pidx[c] = '0;
				ch_step[c] = '0;
				ch_newest[c] = '0;
				ch_older[c] = '0;
			end
			pending_pairs.delete();
		end else begin
			if (pair_out.valid && pair_out.ready) begin
				seen = {pair_out.left_sample, pair_out.right_sample,
					pair_out.last_of_block, pair_out.bad_predictor};
				if (pending_pairs.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_LIMIT)
						$display("unexpected pair: L=%0d R=%0d last=%0b bad=%0b",
							seen.left_sample, seen.right_sample,
							seen.last_of_block, seen.bad_predictor);
				end else begin
					want = pending_pairs.pop_front();
					if (seen.left_sample !== want.left_sample ||
							seen.right_sample !== want.right_sample ||
							seen.last_of_block !== want.last_of_block ||
							seen.bad_predictor !== want.bad_predictor) begin
						mismatch_count++;
						if (mismatch_count <= SHOW_LIMIT)
							$display("pair mismatch: exp L=%0d R=%0d last=%0b bad=%0b,",
								want.left_sample, want.right_sample,
								want.last_of_block, want.bad_predictor,
								" got L=%0d R=%0d last=%0b bad=%0b",
								seen.left_sample, seen.right_sample,
								seen.last_of_block, seen.bad_predictor);
					end
				end
			end
			if (cfg_we) model_block_len = cfg_data;
			if (byte_in.valid && byte_in.ready) decode_byte(byte_in.data_byte);
		end
	end

	// Receiver: stall on a rotating pattern (never in open style); style re-picked after each random run
	always @(posedge clk) begin
		if (rx_run == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_pattern = 16'($urandom);
			rx_run = $urandom_range(16, 96);
		end else begin
			rx_run--;
		end
		rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
		case (rx_mode)
			RX_OPEN: pair_out.ready <= 1'b1;
			RX_DENSE: pair_out.ready <= rx_pattern[0] | rx_pattern[1];
			RX_SPARSE: pair_out.ready <= rx_pattern[0] & rx_pattern[1];
			default: pair_out.ready <= rx_pattern[0];
		endcase
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Send one byte beat; idle in bursts afterwards
	task automatic send_byte(input logic [7:0] b);
		int gap;
		byte_in.valid <= 1'b1;
		byte_in.data_byte <= b;
		@(posedge clk);
		while (!byte_in.ready) @(posedge clk);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 23);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 5);
				byte_in.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop sending and wait until every predicted pair has come out
	task automatic idle_until_drained();
		byte_in.valid <= 1'b0;
		@(posedge clk);
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_block_len(input logic [msad_pkg::SPB_W-1:0] v);
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		len_setting = v;
	endtask

	task automatic send_header(input logic [7:0] idx_l, input logic [7:0] idx_r,
			input logic [15:0] step_l, input logic [15:0] step_r,
			input logic [15:0] new_l, input logic [15:0] new_r,
			input logic [15:0] old_l, input logic [15:0] old_r);
		logic [15:0] words [6];
		words = '{step_l, step_r, new_l, new_r, old_l, old_r};
		send_byte(idx_l);
		send_byte(idx_r);
		foreach (words[i]) begin
			send_byte(words[i][7:0]);
			send_byte(words[i][15:8]);
		end
		open_pairs = (pairs_per_block(len_setting) <= 2) ? 0 : 2;
	endtask

	// Mostly legal indices and moderate steps, sometimes anything
	task automatic send_random_header();
		logic [7:0]  idx [2];
		logic [15:0] st [2];
		foreach (idx[i])
			idx[i] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
		foreach (st[i])
			st[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(16, 2048));
		send_header(idx[0], idx[1], st[0], st[1], 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	task automatic send_data(input int count);
		repeat (count) begin
			send_byte(8'($urandom));
			open_pairs++;
		end
		if (open_pairs >= pairs_per_block(len_setting)) open_pairs = 0;
	endtask

	// Default length, saturating codes, then the length drops below pairs already out
	task automatic test_mid_block_length_change();
		logic [7:0] codes [6];
		codes = '{8'h7F, 8'h80, 8'hF0, 8'h0F, 8'h00, 8'hFF};
		send_header(8'd1, 8'd6, 16'h7FFF, 16'h0001, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		foreach (codes[i]) send_byte(codes[i]);
		open_pairs += 6;
		idle_until_drained();
		write_block_len(14'd3);
		send_byte(8'h88);
		open_pairs = 0;
	endtask

	// Length 0 acts as 2: the header alone is the block; bad indices, negative step
	task automatic test_short_block();
		idle_until_drained();
		write_block_len(14'd0);
		send_header(8'd7, 8'hFF, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF, 16'h1234, 16'hFFFF);
	endtask

	// Top register value: block runs on with no end flag; the next round closes it
	task automatic test_long_block();
		idle_until_drained();
		write_block_len(14'h3FFF);
		send_random_header();
		send_data(LONG_DATA);
	endtask

	// Random lengths and blocks, some cut off by a length change mid-block
	task automatic test_random_blocks();
		int start, eff, data_n;
		logic [msad_pkg::SPB_W-1:0] new_len;
		bit cut;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_ITEMS) begin
			idle_until_drained();
			if ($urandom_range(0, 9) == 0) new_len = 14'($urandom_range(0, 2));
			else new_len = 14'($urandom_range(3, 40));
			write_block_len(new_len);
			eff = pairs_per_block(new_len);
			// finish a block left open by the previous round
			if (open_pairs != 0) send_data(open_pairs >= eff ? 1 : eff - open_pairs);
			cut = 1'b0;
			repeat ($urandom_range(1, 4)) begin
				if (!cut) begin
					send_random_header();
					if (open_pairs != 0) begin
						data_n = eff - 2;
						if ($urandom_range(0, 9) == 0) idle_until_drained();
						if (data_n > 1 && $urandom_range(0, 5) == 0) begin
							data_n = $urandom_range(1, data_n - 1);
							cut = 1'b1;
						end
						send_data(data_n);
					end
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		byte_in.valid = 1'b0;
		byte_in.data_byte = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_mid_block_length_change();
		test_short_block();
		test_long_block();
		test_random_blocks();

		idle_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_pairs.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
